/* hdl/idba_pkg.sv */
// shared types and constants for the id bitmap allocator
`default_nettype none

package idba_pkg;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned ID_SPAN = 256;

  typedef logic [ID_W-1:0]    id_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

endpackage

`default_nettype wire

/* hdl/idba_if.sv */
// request and response channel interfaces of the id bitmap allocator
`default_nettype none

interface idba_req_if;
  import idba_pkg::*;
  logic valid;
  logic ready;
  logic mode;
  id_t  release_id;

  modport source (output valid, output mode, output release_id, input ready);
  modport sink (input valid, input mode, input release_id, output ready);
endinterface

interface idba_rsp_if;
  import idba_pkg::*;
  logic   valid;
  logic   ready;
  id_t    granted_id;
  logic   granted;
  count_t used_count;

  modport source (output valid, output granted_id, output granted, output used_count,
                  input ready);
  modport sink (input valid, input granted_id, input granted, input used_count,
                output ready);
endinterface

`default_nettype wire

/* hdl/id_bitmap_allocator_core.sv */
// id bitmap allocator: first-free allocate and release over a word-wide map memory
// scan: a request reads map words in order from word 0, 1 to NUM_WORDS of them (32 at the
//   defaults); the scan holds on its last word while an earlier response waits
// requests: none is taken while a scan runs; the next is taken the cycle after the scan
// reset: per-word valid flags clear at once, so the whole map reads free without a
//   clearing pass; the used counter clears to zero
`default_nettype none

module id_bitmap_allocator_core #(
  parameter int unsigned NUM_IDS   = 256,
  parameter int unsigned WORD_BITS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  idba_req_if.sink   req_i,
  idba_rsp_if.source rsp_o
);
  import idba_pkg::*;

  localparam int unsigned POOL_SIZE = (NUM_IDS < ID_SPAN) ? NUM_IDS : ID_SPAN;
  localparam int unsigned NUM_WORDS = (POOL_SIZE + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned JW        = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned IW        = 10;

  typedef logic [WORD_BITS-1:0] word_t;

  state_e              state_q, state_d;
  logic                mode_q;
  id_t                 rid_q;
  logic [AW-1:0]       word_q, word_d;
  logic [IW-1:0]       base_q, base_d;
  count_t              count_q, count_d;
  logic [NUM_WORDS-1:0] vld_q;

  word_t               mem [NUM_WORDS];
  word_t               mem_rdata_q;
  logic                rd_vld_q;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  word_t               wr_data;

  logic                out_valid_q;
  id_t                 out_id_q;
  logic                out_granted_q;
  count_t              out_count_q;

  word_t               word_v, pad, free_bits, bit_mask;
  logic                any_free, last_word, hit, rel_set, done, fin, alloc;
  logic [JW-1:0]       free_idx, rel_idx, bit_sel;
  logic [IW-1:0]       rel_off, gid_sum, top_id;

  assign req_i.ready = (state_q == ST_IDLE);
  assign alloc       = (mode_q == MODE_ALLOC);

  // word as stored, free when never written since reset
  assign word_v = rd_vld_q ? mem_rdata_q : '0;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      pad[j] = (base_q + IW'(j)) >= IW'(POOL_SIZE);
    end
  end

  assign free_bits = ~(word_v | pad);
  assign any_free  = |free_bits;

  always_comb begin
    free_idx = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        free_idx = JW'(j);
      end
    end
  end

  assign last_word = (word_q == AW'(NUM_WORDS - 1));
  assign top_id    = base_q + IW'(WORD_BITS);
  assign hit       = ({2'b00, rid_q} < top_id);
  assign rel_off   = {2'b00, rid_q} - base_q;
  assign rel_idx   = rel_off[JW-1:0];
  assign rel_set   = word_v[rel_idx];
  assign bit_sel   = alloc ? free_idx : rel_idx;
  assign bit_mask  = word_t'(1) << bit_sel;
  assign gid_sum   = base_q + IW'(free_idx);

  assign done = alloc ? (any_free || last_word) : (hit || last_word);
  assign fin  = (state_q == ST_SCAN) && done && (!out_valid_q || rsp_o.ready);

  assign wr_en   = fin && (alloc ? any_free : (hit && rel_set));
  assign wr_data = alloc ? (word_v | bit_mask) : (word_v & ~bit_mask);

  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    base_d  = base_q;
    count_d = count_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          rd_en   = 1'b1;
          word_d  = '0;
          base_d  = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!done) begin
          rd_en   = 1'b1;
          rd_addr = word_q + AW'(1);
          word_d  = word_q + AW'(1);
          base_d  = top_id;
        end else if (fin) begin
          state_d = ST_IDLE;
          if (wr_en) begin
            count_d = alloc ? (count_q + COUNT_W'(1)) : (count_q - COUNT_W'(1));
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      word_q      <= '0;
      base_q      <= '0;
      count_q     <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      word_q  <= word_d;
      base_q  <= base_d;
      count_q <= count_d;
      if (wr_en) begin
        vld_q[word_q] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request payload and response payload
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      mode_q <= req_i.mode;
      rid_q  <= req_i.release_id;
    end
    if (fin) begin
      out_granted_q <= alloc && any_free;
      out_id_q      <= (alloc && any_free) ? gid_sum[ID_W-1:0] : '0;
      out_count_q   <= count_d;
    end
  end

  // map memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[word_q] <= wr_data;
    end
    if (rd_en) begin
      mem_rdata_q <= mem[rd_addr];
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.granted_id = out_id_q;
  assign rsp_o.granted    = out_granted_q;
  assign rsp_o.used_count = out_count_q;

endmodule

`default_nettype wire

/* hdl/idba_checker.sv */
// port-level checks of the id bitmap allocator and their binding
`default_nettype none

module idba_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            req_valid_i,
  input wire logic            req_ready_i,
  input wire logic            rsp_valid_i,
  input wire logic            rsp_ready_i,
  input wire idba_pkg::id_t    rsp_granted_id_i,
  input wire logic            rsp_granted_i,
  input wire idba_pkg::count_t rsp_used_count_i
);
  import idba_pkg::*;

  // a grant always leaves at least one id in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_granted_i |-> rsp_used_count_i != '0)
    else $error("grant reported with zero ids in use");

  // a refused or release response carries id zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_granted_i |-> rsp_granted_id_i == '0)
    else $error("non-zero id without a grant");

  // the block is busy scanning in the cycle after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while a scan is running");

  // a stalled response holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_granted_id_i)
      && $stable(rsp_granted_i) && $stable(rsp_used_count_i))
    else $error("response changed while stalled");

endmodule

bind id_bitmap_allocator_core idba_checker u_idba_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_granted_id_i (rsp_o.granted_id),
  .rsp_granted_i    (rsp_o.granted),
  .rsp_used_count_i (rsp_o.used_count)
);

`default_nettype wire

/* tb/tb.sv */
// testbench for the id bitmap allocator: random allocate and release traffic against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import idba_pkg::*;

  localparam int unsigned POOL       = 256;
  localparam int unsigned COUNT_MAX  = 511;
  localparam int unsigned ITEMS      = 950;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_AT    = 150;
  localparam int unsigned HOLD_LEN   = 400;

  typedef struct packed {
    id_t    granted_id;
    logic   granted;
    count_t used_count;
  } grant_t;

  class id_pool_scoreboard;
    bit [POOL-1:0] id_map;
    int unsigned   in_use;
    grant_t        grant_q[$];
    int unsigned   n_noted;
    int unsigned   n_checked;
    int unsigned   errors;

    function new();
      id_map    = '0;
      in_use    = 0;
      n_noted   = 0;
      n_checked = 0;
      errors    = 0;
    endfunction

    // works out the response the block owes for an accepted request
    function void note_request(logic mode, id_t rid);
      grant_t g;
      g = '0;
      if (mode == MODE_ALLOC) begin
        for (int unsigned i = 0; i < POOL; i++) begin
          if (!id_map[i]) begin
            id_map[i]    = 1'b1;
            in_use++;
            g.granted_id = id_t'(i);
            g.granted    = 1'b1;
            break;
          end
        end
      end else if (rid < POOL && id_map[rid]) begin
        id_map[rid] = 1'b0;
        in_use--;
      end
      g.used_count = count_t'(in_use > COUNT_MAX ? COUNT_MAX : in_use);
      grant_q.push_back(g);
      n_noted++;
    endfunction

    function void check_response(id_t gid, logic ok, count_t cnt);
      grant_t g;
      n_checked++;
      if (grant_q.size() == 0) begin
        $error("response with no request outstanding: granted_id %0d", gid);
        errors++;
        return;
      end
      g = grant_q.pop_front();
      if (gid !== g.granted_id) begin
        $error("granted_id: expected %0d, got %0d", g.granted_id, gid);
        errors++;
      end
      if (ok !== g.granted) begin
        $error("granted: expected %0b, got %0b", g.granted, ok);
        errors++;
      end
      if (cnt !== g.used_count) begin
        $error("used_count: expected %0d, got %0d", g.used_count, cnt);
        errors++;
      end
    endfunction

    // a random id that is currently taken, or any id when the pool is empty
    function id_t pick_busy_id();
      int unsigned start;
      start = $urandom_range(0, POOL - 1);
      for (int unsigned i = 0; i < POOL; i++) begin
        if (id_map[(start + i) % POOL]) return id_t'((start + i) % POOL);
      end
      return id_t'(start);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  idba_req_if req_if ();
  idba_rsp_if rsp_if ();

  id_bitmap_allocator_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  id_pool_scoreboard sb;
  logic              hold_off;
  int unsigned       burst_left;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic mode, input id_t rid);
    int unsigned gap;
    if (burst_left == 0 && $urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 40);
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = next_gap();
    end
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= mode;
    req_if.release_id <= rid;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(mode, rid);
  endtask

  task automatic alloc_id();
    send_request(MODE_ALLOC, id_t'($urandom));
  endtask

  task automatic release_id(input id_t rid);
    send_request(MODE_RELEASE, rid);
  endtask

  // response side: random stalls, plus one long hold-off
  initial begin
    bit          rdy;
    int unsigned run_left;
    int unsigned r;
    rdy          = 1'b0;
    run_left     = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready)
        sb.check_response(rsp_if.granted_id, rsp_if.granted, rsp_if.used_count);
      if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          rdy      = 1'b1;
          run_left = $urandom_range(1, 8);
        end else if (r < 85) begin
          rdy      = 1'b0;
          run_left = $urandom_range(0, 3);
        end else if (r < 95) begin
          rdy      = 1'b1;
          run_left = $urandom_range(40, 80);
        end else begin
          rdy      = 1'b0;
          run_left = $urandom_range(15, 50);
        end
      end
      rsp_if.ready <= hold_off ? 1'b0 : rdy;
    end
  end

  // receiver holds off long enough for the request side to back up
  initial begin
    hold_off = 1'b0;
    do @(posedge clk_i); while (sb == null || sb.n_checked < HOLD_AT);
    hold_off <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $error("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int unsigned r;
    rst_ni            = 1'b0;
    burst_left        = 0;
    req_if.valid      = 1'b0;
    req_if.mode       = MODE_ALLOC;
    req_if.release_id = '0;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first grants, hole refill, releases of free ids, field extremes
    send_request(MODE_ALLOC, 8'h00);
    send_request(MODE_ALLOC, 8'hFF);
    alloc_id();
    release_id(8'd1);
    alloc_id();
    release_id(8'd0);
    release_id(8'd0);
    release_id(8'hFF);
    release_id(8'hAA);
    release_id(8'h55);
    alloc_id();
    alloc_id();
    alloc_id();
    release_id(8'd2);
    release_id(8'd3);
    alloc_id();

    // fill the pool
    while (sb.in_use < POOL) begin
      if ($urandom_range(0, 99) < 90) alloc_id();
      else release_id(sb.pick_busy_id());
    end
    // full pool: refused allocations, holes reopened at random
    repeat (16) begin
      if ($urandom_range(0, 99) < 65) alloc_id();
      else release_id(sb.pick_busy_id());
    end
    // drain it again
    while (sb.in_use > 0) begin
      r = $urandom_range(0, 99);
      if (r < 85) release_id(sb.pick_busy_id());
      else if (r < 95) release_id(id_t'($urandom));
      else alloc_id();
    end
    // mixed traffic
    while (sb.n_noted < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 50) alloc_id();
      else if (r < 85) release_id(sb.pick_busy_id());
      else release_id(id_t'($urandom));
    end
    req_if.valid <= 1'b0;

    while (sb.grant_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
